[hw/rtl/cpac_pkg.sv]
// cpac_pkg: shared types, constants and elaboration-time helpers for the
// cluster position asinh correction block. No dependencies.
package cpac_pkg;

  localparam int ENERGY_BITS_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FIELD_W           = 16;
  localparam int SCALE_W           = 24;
  localparam int COEFF_W           = 16;
  localparam int POS_W             = 16;
  localparam int ASINH_W           = 32;

  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd4096;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd154036;
  localparam logic [31:0]        LN2_Q28     = 32'd186065279;

  // register index codes (paddr[2])
  localparam logic REG_COEFF = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  // atanh(2^-i) in Q.28, rounded
  localparam logic [28:0] ATANH_Q28 [25] = '{
    29'd0, 29'd147453245, 29'd68561855, 29'd33730852, 29'd16799113,
    29'd8391340, 29'd4194645, 29'd2097195, 29'd1048581, 29'd524289,
    29'd262144, 29'd131072, 29'd65536, 29'd32768, 29'd16384, 29'd8192,
    29'd4096, 29'd2048, 29'd1024, 29'd512, 29'd256, 29'd128, 29'd64,
    29'd32, 29'd16
  };

  typedef struct packed {
    logic [FIELD_W-1:0] low_energy;
    logic [FIELD_W-1:0] centre_energy;
    logic [FIELD_W-1:0] high_energy;
  } cpac_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    zero_sum;
  } cpac_out_t;

  // sideband that rides along the pipeline with each transaction
  typedef struct packed {
    logic neg;
    logic zero;
  } cpac_tag_t;

  // CORDIC iterations: shifts 1..n, with 4 and 13 done twice
  function automatic int cordic_total(input int n);
    return n + ((n >= 4) ? 1 : 0) + ((n >= 13) ? 1 : 0);
  endfunction

  function automatic int cordic_shift(input int j);
    int c;
    int s;
    c = 0;
    s = 1;
    for (int i = 1; i <= 24; i++) begin
      for (int r = 0; r < 2; r++) begin
        if (r == 0 || i == 4 || i == 13) begin
          if (c == j) s = i;
          c++;
        end
      end
    end
    return s;
  endfunction

  // start-to-done latency of the whole pipeline
  function automatic int cpac_latency(input int n);
    return 59 + cordic_total(n);
  endfunction

endpackage

[hw/rtl/cpac_div.sv]
// cpac_div: pipelined scaling divider, u = round(diff*scale/sum), one
// quotient bit per stage. Depends on cpac_pkg.
module cpac_div #(
  parameter int EW = cpac_pkg::FIELD_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  cpac_pkg::cpac_tag_t             in_tag,
  input  logic [EW-1:0]                   diff,
  input  logic [EW+1:0]                   sum,
  input  logic [cpac_pkg::SCALE_W-1:0]    scale,
  output logic                            out_valid,
  output cpac_pkg::cpac_tag_t             out_tag,
  output logic [cpac_pkg::SCALE_W-1:0]    quot
);
  import cpac_pkg::*;

  localparam int QW = SCALE_W;
  localparam int NW = EW + QW;
  localparam int RW = EW + 2;

  logic            pv;
  cpac_tag_t       pt;
  logic [NW-1:0]   prod;
  logic [RW-1:0]   psum;
  logic [NW-1:0]   num;

  logic            v    [QW+1];
  cpac_tag_t       t    [QW+1];
  logic [RW-1:0]   rem  [QW+1];
  logic [RW-1:0]   dvs  [QW+1];
  logic [QW-1:0]   nlo  [QW+1];
  logic [QW-1:0]   q    [QW+1];
  logic [RW:0]     trial[QW];
  logic            ge   [QW];

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else pv <= in_valid;
    pt   <= in_tag;
    prod <= NW'(diff) * NW'(scale);
    psum <= sum;
  end

  assign num = prod + NW'(psum >> 1);

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      trial[s] = {rem[s], nlo[s][QW-1]};
      ge[s]    = trial[s] >= {1'b0, dvs[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= QW; s++) v[s] <= 1'b0;
    end else begin
      v[0] <= pv;
      for (int s = 0; s < QW; s++) v[s+1] <= v[s];
    end
    t[0]   <= pt;
    rem[0] <= RW'(num[NW-1:QW]);
    dvs[0] <= psum;
    nlo[0] <= num[QW-1:0];
    q[0]   <= '0;
    for (int s = 0; s < QW; s++) begin
      t[s+1]   <= t[s];
      dvs[s+1] <= dvs[s];
      nlo[s+1] <= nlo[s] << 1;
      q[s+1]   <= {q[s][QW-2:0], ge[s]};
      rem[s+1] <= ge[s] ? RW'(trial[s] - {1'b0, dvs[s]}) : trial[s][RW-1:0];
    end
  end

  assign out_valid = v[QW];
  assign out_tag   = t[QW];
  assign quot      = q[QW];

endmodule

[hw/rtl/cpac_asinh.sv]
// cpac_asinh: pipelined asinh of a Q8.16 magnitude: square, digit-by-digit
// square root, normalization and hyperbolic CORDIC log. Depends on cpac_pkg.
module cpac_asinh #(
  parameter int CORDIC_STAGES = cpac_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  cpac_pkg::cpac_tag_t            in_tag,
  input  logic [cpac_pkg::SCALE_W-1:0]   u,
  output logic                           out_valid,
  output cpac_pkg::cpac_tag_t            out_tag,
  output logic [cpac_pkg::ASINH_W-1:0]   asinh
);
  import cpac_pkg::*;

  localparam int T  = cordic_total(CORDIC_STAGES);
  localparam int UW = SCALE_W;
  localparam int SW = 50;
  localparam int SQ = 25;
  localparam int WW = 26;

  // squaring
  logic              av;
  cpac_tag_t         at;
  logic [UW-1:0]     au;
  logic [2*UW-1:0]   asq;

  always_ff @(posedge clk) begin
    if (rst) av <= 1'b0;
    else av <= in_valid;
    at  <= in_tag;
    au  <= u;
    asq <= (2*UW)'(u) * (2*UW)'(u);
  end

  // square root of u*u + 1.0, two radicand bits per stage
  logic            sv [SQ+1];
  cpac_tag_t       st [SQ+1];
  logic [UW-1:0]   su [SQ+1];
  logic [SW-1:0]   sn [SQ+1];
  logic [SW-1:0]   sr [SQ+1];
  logic [SW-1:0]   sb [SQ];
  logic            sge[SQ];

  always_comb begin
    for (int j = 0; j < SQ; j++) begin
      sb[j]  = SW'(1) << (48 - 2*j);
      sge[j] = sn[j] >= sr[j] + sb[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= SQ; j++) sv[j] <= 1'b0;
    end else begin
      sv[0] <= av;
      for (int j = 0; j < SQ; j++) sv[j+1] <= sv[j];
    end
    st[0] <= at;
    su[0] <= au;
    sn[0] <= SW'(asq) + (SW'(1) << 32);
    sr[0] <= '0;
    for (int j = 0; j < SQ; j++) begin
      st[j+1] <= st[j];
      su[j+1] <= su[j];
      sn[j+1] <= sge[j] ? sn[j] - (sr[j] + sb[j]) : sn[j];
      sr[j+1] <= sge[j] ? (sr[j] >> 1) + sb[j] : sr[j] >> 1;
    end
  end

  // w = u + sqrt(u*u + 1)
  logic            wv;
  cpac_tag_t       wt;
  logic [WW-1:0]   w;

  always_ff @(posedge clk) begin
    if (rst) wv <= 1'b0;
    else wv <= sv[SQ];
    wt <= st[SQ];
    w  <= WW'(su[SQ]) + WW'(sr[SQ][24:0]);
  end

  // w = 2^k * m, m in [1,2) as Q.28
  logic [3:0]   kk;
  logic [28:0]  mant;

  always_comb begin
    kk = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if ((w >> (17 + i)) != '0) kk = 4'(i + 1);
    end
    mant = 29'(({12'b0, w} << 12) >> kk);
  end

  // CORDIC vectoring
  logic               cv [T+1];
  cpac_tag_t          ct [T+1];
  logic [3:0]         ck [T+1];
  logic signed [31:0] cx [T+1];
  logic signed [31:0] cy [T+1];
  logic signed [31:0] cz [T+1];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else cv[0] <= wv;
    ct[0] <= wt;
    ck[0] <= kk;
    cx[0] <= signed'(32'(mant)) + 32'sd268435456;
    cy[0] <= signed'(32'(mant)) - 32'sd268435456;
    cz[0] <= '0;
  end

  for (genvar s = 0; s < T; s++) begin : g_cordic
    localparam int SH = cordic_shift(s);
    always_ff @(posedge clk) begin
      if (rst) cv[s+1] <= 1'b0;
      else cv[s+1] <= cv[s];
      ct[s+1] <= ct[s];
      ck[s+1] <= ck[s];
      if (!cy[s][31]) begin
        cx[s+1] <= cx[s] - (cy[s] >>> SH);
        cy[s+1] <= cy[s] - (cx[s] >>> SH);
        cz[s+1] <= cz[s] + signed'(32'(ATANH_Q28[SH]));
      end else begin
        cx[s+1] <= cx[s] + (cy[s] >>> SH);
        cy[s+1] <= cy[s] + (cx[s] >>> SH);
        cz[s+1] <= cz[s] - signed'(32'(ATANH_Q28[SH]));
      end
    end
  end

  // asinh = k*ln2 + 2z, clamped at zero
  logic signed [33:0] asum;
  logic               ov;
  cpac_tag_t          ot;
  logic [ASINH_W-1:0] oa;

  assign asum = signed'(34'(ck[T]) * 34'(LN2_Q28)) + (34'(cz[T]) <<< 1);

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else ov <= cv[T];
    ot <= ct[T];
    oa <= asum[33] ? '0 : asum[ASINH_W-1:0];
  end

  assign out_valid = ov;
  assign out_tag   = ot;
  assign asinh     = oa;

endmodule

[hw/rtl/cluster_position_asinh_correction.sv]
// cluster_position_asinh_correction: top level, APB register bank, input
// and output stages. Depends on cpac_pkg, cpac_div, cpac_asinh.
//
//  channel   | handshake         | payload
//  ----------+-------------------+----------------------------------------
//  input     | start / busy      | in_item (cpac_in_t: three cell energies)
//  result    | done (1 cycle)    | result (cpac_out_t: position, zero_sum)
//  config    | APB psel/penable  | shape_coeff @0x0, sinh_scale @0x4
//
// One transaction enters per clock; busy is never raised. The depth of
// the pipeline is set by the 24-step divider, the 25-step square root and
// the CORDIC chain.
// rst (synchronous) clears all valid bits and reloads the registers.
// The receiver cannot hold results off, so nothing in the pipe ever stalls.
module cluster_position_asinh_correction #(
  parameter int ENERGY_BITS   = cpac_pkg::ENERGY_BITS_DEF,
  parameter int CORDIC_STAGES = cpac_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cpac_pkg::cpac_in_t in_item,
  output logic               done,
  output cpac_pkg::cpac_out_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cpac_pkg::*;

  // energies wider than the field hold nothing extra
  localparam int EW = (ENERGY_BITS < FIELD_W) ? ENERGY_BITS : FIELD_W;

  // ---------------- registers ----------------
  logic [COEFF_W-1:0] shape_coeff;
  logic [SCALE_W-1:0] sinh_scale;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_coeff <= COEFF_RESET;
      sinh_scale  <= SCALE_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_COEFF: shape_coeff <= pwdata[COEFF_W-1:0];
        REG_SCALE: sinh_scale  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COEFF: prdata = 32'(shape_coeff);
      REG_SCALE: prdata = 32'(sinh_scale);
      default:   prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  // sum, |high - low| and its sign; sign is reapplied at the end (asinh is odd)
  assign busy = 1'b0;

  logic [EW-1:0]   lo, hi, ce;
  logic            iv;
  cpac_tag_t       itag;
  logic [EW-1:0]   idiff;
  logic [EW+1:0]   isum;
  logic [EW+1:0]   sum_next;

  assign lo = in_item.low_energy[EW-1:0];
  assign ce = in_item.centre_energy[EW-1:0];
  assign hi = in_item.high_energy[EW-1:0];
  assign sum_next = (EW+2)'(lo) + (EW+2)'(ce) + (EW+2)'(hi);

  always_ff @(posedge clk) begin
    if (rst) iv <= 1'b0;
    else iv <= start && !busy;
    itag.neg  <= lo > hi;
    itag.zero <= sum_next == '0;
    idiff     <= (lo > hi) ? lo - hi : hi - lo;
    isum      <= sum_next;
  end

  // ---------------- u = round(diff*S/sum) ----------------
  logic               dv;
  cpac_tag_t          dtag;
  logic [SCALE_W-1:0] u;

  cpac_div #(.EW(EW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (iv),
    .in_tag   (itag),
    .diff     (idiff),
    .sum      (isum),
    .scale    (sinh_scale),
    .out_valid(dv),
    .out_tag  (dtag),
    .quot     (u)
  );

  // ---------------- asinh(u) in Q.28 ----------------
  logic               av;
  cpac_tag_t          atag;
  logic [ASINH_W-1:0] a;

  cpac_asinh #(.CORDIC_STAGES(CORDIC_STAGES)) u_asinh (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dv),
    .in_tag   (dtag),
    .u        (u),
    .out_valid(av),
    .out_tag  (atag),
    .asinh    (a)
  );

  // ---------------- coeff * asinh / 2 ----------------
  localparam int PW = COEFF_W + ASINH_W;

  logic            mv;
  cpac_tag_t       mtag;
  logic [PW-1:0]   prod;
  logic [PW:0]     rnd;
  logic [PW-27:0]  mag;
  logic [POS_W-1:0] pos_next;

  always_ff @(posedge clk) begin
    if (rst) mv <= 1'b0;
    else mv <= av;
    mtag <= atag;
    prod <= PW'(shape_coeff) * PW'(a);
  end

  // Q.40 -> Q.14, half up on the magnitude, then saturate per sign
  assign rnd = (PW+1)'(prod) + ((PW+1)'(1) << 26);
  assign mag = rnd[PW:27];

  always_comb begin
    if (mtag.zero) begin
      pos_next = '0;
    end else if (mtag.neg) begin
      if (mag > (PW-26)'(32768)) pos_next = 16'h8000;
      else pos_next = POS_W'((PW-26)'(0) - mag);
    end else begin
      if (mag > (PW-26)'(32767)) pos_next = 16'h7FFF;
      else pos_next = mag[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= mv;
    result.position <= signed'(pos_next);
    result.zero_sum <= mtag.zero;
  end

endmodule

[hw/rtl/cpac_checker.sv]
// cpac_checker: port-level assertions for the correction block, bound to
// the top level below. Depends on cpac_pkg.
module cpac_checker #(
  parameter int LAT = cpac_pkg::cpac_latency(cpac_pkg::CORDIC_STAGES_DEF)
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input cpac_pkg::cpac_in_t  in_item,
  input logic                done,
  input cpac_pkg::cpac_out_t result
);
  import cpac_pkg::*;

  // every accepted transaction produces its result a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing after accepted transaction");

  // an all-zero cluster yields the zero-sum flag
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_item.low_energy == '0 && in_item.centre_energy == '0 &&
     in_item.high_energy == '0) |-> ##LAT (done && result.zero_sum))
    else $error("zero-sum flag not raised");

  // flagged results carry position zero
  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_sum) |-> (result.position == '0))
    else $error("nonzero position with zero sum");

  // reset flushes the pipeline
  a_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind cluster_position_asinh_correction cpac_checker #(
  .LAT(cpac_pkg::cpac_latency(CORDIC_STAGES))
) u_cpac_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .in_item(in_item),
  .done   (done),
  .result (result)
);

[verif/cpac_checker.sv]
// cpac_scoreboard: watches the config, input and result channels of the asinh
// position correction block, predicts each result and compares. Uses cpac_pkg.
module cpac_scoreboard (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  cpac_pkg::cpac_in_t  in_item,
  input  logic                done,
  input  cpac_pkg::cpac_out_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  errors,
  output int                  pending,
  output int                  checked,
  output int                  zero_seen
);
  import cpac_pkg::*;

  logic [COEFF_W-1:0] coeff_q;
  logic [SCALE_W-1:0] scale_q;
  cpac_out_t          expected_positions[$];

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // asinh of a Q8.16 magnitude, Q.28 result: ln(u + sqrt(u^2+1))
  function automatic longint asinh_fixed(input longint unsigned u);
    longint unsigned w;
    int k, stages;
    longint m, x, y, z, nx, ny;
    w = u + int_sqrt(u * u + (64'd1 << 32));
    k = 0;
    while (k < 9 && (w >> (17 + k)) != 0) k++;
    m = longint'(w << (12 - k));
    x = m + (64'sd1 <<< 28);
    y = m - (64'sd1 <<< 28);
    z = 0;
    stages = CORDIC_STAGES_DEF;
    if (stages < 1) stages = 1;
    if (stages > 24) stages = 24;
    for (int i = 1; i <= stages; i++) begin
      for (int rep = 0; rep < ((i == 4 || i == 13) ? 2 : 1); rep++) begin
        if (y >= 0) begin
          nx = x - (y >>> i);
          ny = y - (x >>> i);
          z += longint'(ATANH_Q28[i]);
        end else begin
          nx = x + (y >>> i);
          ny = y + (x >>> i);
          z -= longint'(ATANH_Q28[i]);
        end
        x = nx;
        y = ny;
      end
    end
    return longint'(k) * longint'(LN2_Q28) + 2 * z;
  endfunction

  function automatic cpac_out_t correct_position(input cpac_in_t it);
    cpac_out_t o;
    longint unsigned lo, ce, hi, sum, diff, u, mag;
    longint a;
    logic neg;
    lo = it.low_energy;
    ce = it.centre_energy;
    hi = it.high_energy;
    sum = lo + ce + hi;
    o.position = '0;
    o.zero_sum = 1'b1;
    if (sum == 0) return o;
    neg = lo > hi;
    diff = neg ? lo - hi : hi - lo;
    u = (diff * scale_q + (sum >> 1)) / sum;
    a = asinh_fixed(u);
    if (a < 0) a = 0;
    mag = (longint'(coeff_q) * longint'(a) + (64'd1 << 26)) >> 27;
    if (neg) begin
      if (mag > 32768) mag = 32768;
      o.position = 16'(0 - mag);
    end else begin
      if (mag > 32767) mag = 32767;
      o.position = 16'(mag);
    end
    o.zero_sum = 1'b0;
    return o;
  endfunction

  initial begin
    errors = 0;
    checked = 0;
    zero_seen = 0;
  end

  assign pending = expected_positions.size();

  always @(posedge clk) begin
    cpac_out_t want;
    if (rst) begin
      coeff_q <= COEFF_RESET;
      scale_q <= SCALE_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_COEFF) coeff_q <= pwdata[COEFF_W-1:0];
        else                       scale_q <= pwdata[SCALE_W-1:0];
      end
      if (start && !busy) expected_positions.push_back(correct_position(in_item));
      if (done) begin
        if (expected_positions.size() == 0) begin
          report("unexpected result", result.position, 0);
        end else begin
          want = expected_positions.pop_front();
          if (result.position !== want.position)
            report("position", result.position, want.position);
          if (result.zero_sum !== want.zero_sum)
            report("zero_sum", result.zero_sum, want.zero_sum);
          if (want.zero_sum) zero_seen++;
        end
        checked++;
      end
    end
  end
endmodule

[verif/tb_cluster_position_asinh_correction.sv]
// tb_cluster_position_asinh_correction: stimulus and verdict for the asinh
// position correction block. Depends on cpac_pkg, the block and cpac_scoreboard.
module tb_cluster_position_asinh_correction;
  import cpac_pkg::*;

  localparam int  N_RANDOM    = 1150;
  localparam int  DRAIN       = 120;      // exceeds the pipeline latency
  localparam longint LIMIT    = 400000;   // far above the slowest correct run

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cpac_in_t    in_item = '0;
  logic        done;
  cpac_out_t   result;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          errors, pending, checked, zero_seen;
  int          idle_pct;      // sender idling, percent of cycles
  int          n_configs;
  longint      cycles = 0;

  always #4 clk = ~clk;

  cluster_position_asinh_correction DUT (
    .clk, .rst, .start, .busy, .in_item, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cpac_scoreboard u_scoreboard (
    .clk, .rst, .start, .busy, .in_item, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .checked, .zero_seen
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // one transaction; start stays high across back-to-back items
  task automatic send_cells(input logic [15:0] lo, ce, hi);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{low_energy: lo, centre_energy: ce, high_energy: hi};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // register writes only happen with the pipe empty
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_shape(input logic [15:0] coeff, input logic [23:0] scale);
    drain_pipe();
    apb_write(REG_COEFF, 32'(coeff) | (32'($urandom) << 16));  // upper bits ignored
    apb_write(REG_SCALE, 32'(scale) | (32'($urandom) << 24));
    n_configs++;
  endtask

  // random energy: mostly full range, some extremes, some tiny clusters
  function automatic logic [15:0] rand_energy();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] cf;
    logic [23:0] sc;
    n_configs = 0;
    idle_pct = 21;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, at reset register values: zero sum, both edges, balance
    send_cells(16'd0, 16'd0, 16'd0);
    send_cells(16'hFFFF, 16'd0, 16'd0);
    send_cells(16'd0, 16'd0, 16'hFFFF);
    send_cells(16'd0, 16'hFFFF, 16'd0);
    send_cells(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cells(16'd1, 16'd0, 16'd0);
    send_cells(16'd0, 16'd0, 16'd1);
    send_cells(16'd1, 16'd1, 16'd2);
    send_cells(16'd1000, 16'd5000, 16'd1000);
    send_cells(16'd1, 16'hFFFF, 16'd0);
    send_cells(16'hFFFE, 16'hFFFF, 16'hFFFF);
    send_cells(16'h5555, 16'hAAAA, 16'h5555 ^ 16'hFFFF);

    // extreme register settings, including zero sinh_scale and saturation
    load_shape(16'hFFFF, 24'hFFFFFF);
    send_cells(16'd0, 16'd0, 16'hFFFF);
    send_cells(16'hFFFF, 16'd0, 16'd0);
    send_cells(16'd10, 16'd100, 16'd20);
    load_shape(16'd1, 24'd0);
    send_cells(16'd0, 16'd0, 16'hFFFF);
    send_cells(16'd7, 16'd3, 16'd0);
    load_shape(16'd1, 24'hFFFFFF);
    send_cells(16'hFFFF, 16'd1, 16'd0);
    send_cells(16'd0, 16'd0, 16'd0);
    load_shape(16'hFFFF, 24'd0);
    send_cells(16'd1, 16'd2, 16'd3);

    // random part in three idling phases, register settings varied per block
    for (int blk = 0; blk < 10; blk++) begin
      case (blk % 5)
        0: begin cf = COEFF_RESET; sc = SCALE_RESET; end
        1: begin cf = 16'hFFFF; sc = 24'hFFFFFF; end
        2: begin cf = 16'd1 + 16'($urandom_range(16'hFFFE)); sc = 24'($urandom); end
        3: begin cf = 16'd2048 + 16'($urandom_range(8192)); sc = 24'($urandom_range(600000)); end
        default: begin cf = 16'($urandom_range(1, 65535)); sc = 24'($urandom_range(3)); end
      endcase
      load_shape(cf, sc);
      for (int n = 0; n < N_RANDOM / 10; n++) begin
        idle_pct = (blk * 3 < 10) ? 21 : (blk * 3 < 20) ? 84 : 0;
        send_cells(rand_energy(), rand_energy(), rand_energy());
      end
    end

    drain_pipe();
    $display("covered %0d results (%0d with zero energy sum) over %0d register settings",
             checked, zero_seen, n_configs);
    $display("sender idling 21%%, 84%% and none; all registers at reset and extreme values");
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
